// ===== rtl/debugger_packet_deframer_defines.svh =====
// Assertion macros used by the checker of the deframer.
`ifndef DEBUGGER_PACKET_DEFRAMER_DEFINES_SVH
`define DEBUGGER_PACKET_DEFRAMER_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define DPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define DPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dpd_pkg;

  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CH_START = 8'h24;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_NAK   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_INTR  = 8'h03;

  typedef enum logic [2:0] {
    KIND_BYTE   = 3'd0,
    KIND_EMPTY  = 3'd1,
    KIND_NAK    = 3'd2,
    KIND_RESEND = 3'd3,
    KIND_INTR   = 3'd4
  } kind_t;

  typedef struct packed {
    logic  vld;
    kind_t kind;
    logic  from_mem;
    logic  last;
  } dpd_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dpd_payload_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dpd_payload_ram
  import dpd_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dpd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dpd_parser
  import dpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64,
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              out_free,
  output dpd_res_t               res,
  output logic                   wr_en,
  output logic      [AW-1:0]     wr_addr,
  output logic      [BYTE_W-1:0] wr_data,
  output logic                   rd_en,
  output logic      [AW-1:0]     rd_addr
);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_PAYLOAD,
    PH_CHECK,
    PH_DRAIN
  } phase_t;

  phase_t            phase;
  logic [CW-1:0]     count;
  logic [BYTE_W-1:0] sum;
  logic              ovf;
  logic [3:0]        first_digit;
  logic              first_valid;
  logic              digits_seen;
  logic [AW-1:0]     rd_idx;
  logic              rd_pend;
  logic              pend_last;

  logic              accept;
  hex_t              hx;
  logic [BYTE_W-1:0] cs_value;
  logic              cs_match;
  logic              has_room;
  logic              issue_last;

  assign in_ready = (phase != PH_DRAIN) && !rd_pend && out_free;
  assign accept   = in_valid && in_ready;
  assign hx       = hex_decode(in_byte);
  assign has_room = count < CW'(MAX_PAYLOAD);

  always_comb begin
    if (!first_valid) begin
      cs_value = '0;
    end else if (hx.ok) begin
      cs_value = {first_digit, hx.val};
    end else begin
      cs_value = {4'd0, first_digit};
    end
  end

  assign cs_match = (cs_value == sum) && !ovf;

  assign wr_en   = accept && (phase == PH_PAYLOAD) && (in_byte != CH_HASH) && has_room;
  assign wr_addr = count[AW-1:0];
  assign wr_data = in_byte;

  assign rd_en      = (phase == PH_DRAIN) && out_free && !rd_pend;
  assign rd_addr    = rd_idx;
  assign issue_last = (CW'(rd_idx) + CW'(1)) == count;

  always_comb begin
    res          = '0;
    res.kind     = KIND_BYTE;
    if (rd_pend) begin
      res.vld      = 1'b1;
      res.from_mem = 1'b1;
      res.last     = pend_last;
    end else if (accept) begin
      unique case (phase)
        PH_SEARCH: begin
          if (in_byte == CH_NAK) begin
            res.vld  = 1'b1;
            res.kind = KIND_RESEND;
            res.last = 1'b1;
          end else if (in_byte == CH_INTR) begin
            res.vld  = 1'b1;
            res.kind = KIND_INTR;
            res.last = 1'b1;
          end
        end
        PH_CHECK: begin
          if (in_byte != CH_HASH && digits_seen) begin
            if (!cs_match) begin
              res.vld  = 1'b1;
              res.kind = KIND_NAK;
              res.last = 1'b1;
            end else if (count == '0) begin
              res.vld  = 1'b1;
              res.kind = KIND_EMPTY;
              res.last = 1'b1;
            end
          end
        end
        PH_PAYLOAD, PH_DRAIN: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEARCH;
      count       <= '0;
      sum         <= '0;
      ovf         <= 1'b0;
      first_digit <= '0;
      first_valid <= 1'b0;
      digits_seen <= 1'b0;
      rd_idx      <= '0;
      rd_pend     <= 1'b0;
      pend_last   <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (rd_en) begin
        pend_last <= issue_last;
      end
      unique case (phase)
        PH_SEARCH: begin
          if (accept && in_byte == CH_START) begin
            phase       <= PH_PAYLOAD;
            count       <= '0;
            sum         <= '0;
            ovf         <= 1'b0;
            first_digit <= '0;
            first_valid <= 1'b0;
            digits_seen <= 1'b0;
          end
        end
        PH_PAYLOAD: begin
          if (accept) begin
            if (in_byte == CH_HASH) begin
              phase       <= PH_CHECK;
              digits_seen <= 1'b0;
              first_valid <= 1'b0;
              first_digit <= '0;
            end else begin
              sum <= sum + in_byte;
              if (has_room) begin
                count <= count + CW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end
          end
        end
        PH_CHECK: begin
          if (accept && in_byte != CH_HASH) begin
            if (!digits_seen) begin
              first_digit <= hx.val;
              first_valid <= hx.ok;
              digits_seen <= 1'b1;
            end else begin
              sum         <= '0;
              ovf         <= 1'b0;
              first_digit <= '0;
              first_valid <= 1'b0;
              digits_seen <= 1'b0;
              rd_idx      <= '0;
              if (cs_match && count != '0) begin
                phase <= PH_DRAIN;
              end else begin
                phase <= PH_SEARCH;
                count <= '0;
              end
            end
          end
        end
        PH_DRAIN: begin
          if (rd_en) begin
            rd_idx <= rd_idx + AW'(1);
            if (issue_last) begin
              phase <= PH_SEARCH;
              count <= '0;
            end
          end
        end
        default: begin
          phase <= PH_SEARCH;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/debugger_packet_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Debugger packet deframer.
// Slave stream: one received link byte per request in s_axis_tdata.
// Master stream: results; tuser carries the kind (payload byte, empty packet,
// send NAK, resend last reply, interrupt), tdata the payload byte (zero for
// other kinds), tlast marks the final result caused by one input byte.
// A '$' opens a packet; payload up to '#' goes to an on-chip payload memory
// of MAX_PAYLOAD bytes while its modulo-256 sum is tracked; two hex checksum
// characters close it. A good packet is replayed from the memory.
// Throughput: one input byte per cycle while the output register is free or
// being taken and no replay is in progress. A control result appears on the
// master side in the cycle after the causing byte. A good packet is replayed
// one byte at a time: registered memory read, then the output register, with
// the next read only after that; intake stays blocked until replay is done.
// Reset clears the parser to searching for '$' and empties the output
// register; the payload memory needs no clearing. When the receiver stalls,
// the output register holds its result and intake and replay pause.
module debugger_packet_deframer
  import dpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] rx_byte
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [BYTE_W-1:0] m_axis_tdata,   // [7:0] data
  output logic      [2:0]        m_axis_tuser,   // [2:0] kind
  output logic                   m_axis_tlast
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  dpd_res_t          res;
  logic              out_free;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  logic              o_valid;
  kind_t             o_kind;
  logic [BYTE_W-1:0] o_data;
  logic              o_last;

  assign out_free = !o_valid || m_axis_tready;

  dpd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW         (AW),
    .CW         (CW)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_byte (s_axis_tdata),
    .out_free(out_free),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  dpd_payload_ram #(
    .DEPTH(MAX_PAYLOAD),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (res.vld) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      o_kind <= res.kind;
      o_data <= res.from_mem ? rd_data : '0;
      o_last <= res.last;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;
  assign m_axis_tuser  = o_kind;
  assign m_axis_tlast  = o_last;

endmodule
`default_nettype wire

// ===== rtl/dpd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "debugger_packet_deframer_defines.svh"
module dpd_checker
  import dpd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [BYTE_W-1:0] m_axis_tdata,
  input wire logic [2:0]        m_axis_tuser,
  input wire logic              m_axis_tlast
);

  `DPD_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
  `DPD_ASSERT(a_kind, m_axis_tvalid |-> m_axis_tuser == KIND_BYTE || m_axis_tuser == KIND_EMPTY || m_axis_tuser == KIND_NAK || m_axis_tuser == KIND_RESEND || m_axis_tuser == KIND_INTR, "bad result kind")
  `DPD_ASSERT(a_ctl_zero, m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tdata == '0, "control result with data")
  `DPD_ASSERT(a_ctl_last, m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tlast, "control result without last")
  `DPD_ASSERT_ALWAYS(a_rst_idle, $past(rst) && !rst |-> !m_axis_tvalid, "result right after reset")

endmodule

bind debugger_packet_deframer dpd_checker u_dpd_checker (.*);
`default_nettype wire
